// ----- sv/b64le_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the alphabet function of the line-wrapping Base64 encoder.
// Used by the channel interfaces and by every module of the block.
package b64le_pkg;

  localparam int ByteWidth  = 8;
  localparam int CharWidth  = 7;
  localparam int GplWidth   = 8;
  localparam int QueueDepth = 4;
  localparam int JobChars   = 4;
  localparam int CharIdxW   = $clog2(JobChars);

  localparam logic [GplWidth-1:0]  GplReset    = 8'd12;
  localparam logic [CharWidth-1:0] PadChar     = 7'd61;
  localparam logic [CharWidth-1:0] NewlineChar = 7'd10;

  localparam int CfgAddrWidth = 3;
  localparam logic [CfgAddrWidth-1:0] RegGroupsPerLine = 3'd0;

  typedef struct packed {
    logic [JobChars-1:0][CharWidth-1:0] chars;
    logic [CharIdxW-1:0]                last_idx;
    logic                               fin;
  } b64le_job_t;

  function automatic logic [CharWidth-1:0] sextet_char(input logic [5:0] v);
    logic [CharWidth-1:0] c;
    begin
      if (v < 6'd26) begin
        c = 7'd65 + {1'b0, v};
      end else if (v < 6'd52) begin
        c = 7'd71 + {1'b0, v};
      end else if (v < 6'd62) begin
        c = {1'b0, v} - 7'd4;
      end else if (v == 6'd62) begin
        c = 7'd43;
      end else begin
        c = 7'd47;
      end
      return c;
    end
  endfunction

endpackage

// ----- sv/b64le_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the byte input and the character output.
// Depends on b64le_pkg for the field widths.
interface b64le_byte_if
  import b64le_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] data_byte;
  logic                 final_byte;

  modport source(output valid, data_byte, final_byte, input ready);
  modport sink(input valid, data_byte, final_byte, output ready);
endinterface

interface b64le_char_if
  import b64le_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] out_char;
  logic                 run_last;
  logic                 message_end;

  modport source(output valid, out_char, run_last, message_end, input ready);
  modport sink(input valid, out_char, run_last, message_end, output ready);
endinterface

// ----- sv/b64le_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input bytes, tracks group phase and line position, and builds
// the characters each byte causes as one job. Depends on b64le_pkg and b64le_if.
module b64le_front
  import b64le_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  b64le_byte_if.sink          byte_in,
  input  logic [GplWidth-1:0] groups_per_line,
  output logic                push_valid,
  input  logic                push_ready,
  output b64le_job_t          push_job
);

  typedef enum logic [2:0] {
    PH0 = 3'b001,
    PH1 = 3'b010,
    PH2 = 3'b100
  } phase_t;

  phase_t              phase, phase_next;
  logic [3:0]          leftover, leftover_next;
  logic [GplWidth-1:0] line_count, line_count_next;
  logic [GplWidth-1:0] count_inc;
  logic [7:0]          d;
  logic                fin;
  b64le_job_t          job;

  assign d   = byte_in.data_byte;
  assign fin = byte_in.final_byte;

  always_comb begin
    job             = '0;
    phase_next      = phase;
    leftover_next   = leftover;
    line_count_next = line_count;
    count_inc       = line_count + 8'd1;
    job.fin         = fin;
    case (phase)
      PH1: begin
        job.chars[0] = sextet_char({leftover[1:0], d[7:4]});
        if (fin) begin
          job.chars[1] = sextet_char({d[3:0], 2'b00});
          job.chars[2] = PadChar;
          job.last_idx = 2'd2;
        end else begin
          job.last_idx  = 2'd0;
          leftover_next = d[3:0];
          phase_next    = PH2;
        end
      end
      PH2: begin
        job.chars[0] = sextet_char({leftover, d[7:6]});
        job.chars[1] = sextet_char(d[5:0]);
        job.last_idx = 2'd1;
        if (!fin) begin
          if (count_inc == groups_per_line) begin
            job.chars[2]    = NewlineChar;
            job.last_idx    = 2'd2;
            line_count_next = '0;
          end else begin
            line_count_next = count_inc;
          end
          leftover_next = '0;
          phase_next    = PH0;
        end
      end
      default: begin
        job.chars[0] = sextet_char(d[7:2]);
        if (fin) begin
          job.chars[1] = sextet_char({d[1:0], 4'b0000});
          job.chars[2] = PadChar;
          job.chars[3] = PadChar;
          job.last_idx = 2'd3;
        end else begin
          job.last_idx  = 2'd0;
          leftover_next = {2'b00, d[1:0]};
          phase_next    = PH1;
        end
      end
    endcase
    if (fin) begin
      phase_next      = PH0;
      leftover_next   = '0;
      line_count_next = '0;
    end
  end

  assign push_valid    = byte_in.valid;
  assign byte_in.ready = push_ready;
  assign push_job      = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH0;
      leftover   <= '0;
      line_count <= '0;
    end else if (byte_in.valid && push_ready) begin
      phase      <= phase_next;
      leftover   <= leftover_next;
      line_count <= line_count_next;
    end
  end

endmodule

// ----- sv/b64le_queue.sv -----
`timescale 1ns / 1ps
// Short job queue between the front end and the character sequencer.
// Depends on b64le_pkg for the job type.
module b64le_queue
  import b64le_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  b64le_job_t push_job,
  output logic       head_valid,
  input  logic       pop,
  output b64le_job_t head_job
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  b64le_job_t      slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign push_ready = (count != FullCnt);
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/b64le_back.sv -----
`timescale 1ns / 1ps
// Back end: steps through the characters of the head job and drives one character
// per beat from an output register. Depends on b64le_pkg and b64le_if.
module b64le_back
  import b64le_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  b64le_job_t head_job,
  output logic       pop,
  b64le_char_if.source char_out
);

  logic [CharIdxW-1:0]  idx;
  logic                 load, at_last;
  logic                 out_valid;
  logic [CharWidth-1:0] out_char;
  logic                 run_last, message_end;

  assign at_last = (idx == head_job.last_idx);
  assign load    = head_valid && (!out_valid || char_out.ready);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + 1'b1;
      end else if (char_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= head_job.chars[idx];
      run_last    <= at_last;
      message_end <= at_last && head_job.fin;
    end
  end

  assign char_out.valid       = out_valid;
  assign char_out.out_char    = out_char;
  assign char_out.run_last    = run_last;
  assign char_out.message_end = message_end;

endmodule

// ----- sv/base64_line_wrapping_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the line-wrapping Base64 encoder: front end, job queue, character
// sequencer and the APB register. Depends on b64le_pkg, b64le_if and the submodules.
//
// Raw bytes enter on byte_in, one per beat, with final_byte set on the last byte of
// a message. Base64 characters leave on char_out, one per beat; run_last marks the
// last character caused by a byte and message_end the last character of a message.
// A newline follows every groups_per_line complete three-byte groups, except after
// the final group. groups_per_line is written through the APB port at address 0.
// A byte's characters pass through the job queue and then the output register. A byte
// yields one to four characters; the sequencer sends one character per cycle while
// the receiver is ready, and the front end takes one byte per cycle while the queue
// has room. Reset empties the queue, clears the group and line state and sets
// groups_per_line to twelve. When the receiver stalls, the output holds its beat,
// the queue fills and byte_in.ready then falls until room is made.
module base64_line_wrapping_encoder
  import b64le_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                    clk,
  input  logic                    rst,
  b64le_byte_if.sink              byte_in,
  b64le_char_if.source            char_out,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [GplWidth-1:0] groups_per_line;
  logic                q_push_valid, q_push_ready, q_head_valid, q_pop;
  b64le_job_t          q_push_job, q_head_job;
  logic                reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = ({paddr[CfgAddrWidth-1:2], 2'b00} == RegGroupsPerLine);
  assign prdata  = reg_hit ? {24'd0, groups_per_line} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_line <= GplReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      groups_per_line <= pwdata[GplWidth-1:0];
    end
  end

  b64le_front u_front (
    .clk            (clk),
    .rst            (rst),
    .byte_in        (byte_in),
    .groups_per_line(groups_per_line),
    .push_valid     (q_push_valid),
    .push_ready     (q_push_ready),
    .push_job       (q_push_job)
  );

  b64le_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_job  (q_push_job),
    .head_valid(q_head_valid),
    .pop       (q_pop),
    .head_job  (q_head_job)
  );

  b64le_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_head_valid),
    .head_job  (q_head_job),
    .pop       (q_pop),
    .char_out  (char_out)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    char_out.valid && char_out.message_end |-> char_out.run_last)
    else $error("message end without run end");

  a_fin_has_padding: assert property (@(posedge clk) disable iff (rst)
    q_push_valid && q_push_ready && q_push_job.fin |-> q_push_job.last_idx != 2'd0)
    else $error("final job with a single character");

  a_four_only_final: assert property (@(posedge clk) disable iff (rst)
    q_push_valid && q_push_ready && q_push_job.last_idx == 2'd3 |-> q_push_job.fin)
    else $error("four-character job without final flag");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("pop from an empty queue");

endmodule
